### rtl/rrqs_pkg.sv
`timescale 1ns / 1ps

package rrqs_pkg;

  localparam int unsigned TimeW = 25;
  localparam int unsigned SumW  = 32;
  localparam int unsigned JobW  = 8;
  localparam int unsigned ValW  = 16;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
  localparam logic [SumW-1:0]  SumMax  = {SumW{1'b1}};

  // Operation carried on the input word's tuser.
  localparam logic OpAdd      = 1'b0;
  localparam logic OpDispatch = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_RUN   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Scheduling key, most significant part first.
  typedef struct packed {
    logic [TimeW-1:0] ready_time;
    logic             requeued;
    logic [JobW-1:0]  job;
  } key_t;

  typedef struct packed {
    logic [ValW-1:0] arrival;
    logic [ValW-1:0] burst;
    logic [ValW-1:0] remaining;
    key_t            key;
  } entry_t;

endpackage

### rtl/rrqs_entry_mem.sv
`timescale 1ns / 1ps

module rrqs_entry_mem
  import rrqs_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/rrqs_key_cmp.sv
`timescale 1ns / 1ps

module rrqs_key_cmp
  import rrqs_pkg::*;
(
  input  key_t a_i,
  input  key_t b_i,
  output logic a_less_o
);

  // Earlier ready time wins, then a fresh job over a requeued one, then the
  // lower job number.
  always_comb begin
    if (a_i.ready_time != b_i.ready_time) begin
      a_less_o = a_i.ready_time < b_i.ready_time;
    end else if (a_i.requeued != b_i.requeued) begin
      a_less_o = !a_i.requeued;
    end else begin
      a_less_o = a_i.job < b_i.job;
    end
  end

endmodule

### rtl/round_robin_quantum_scheduler.sv
`timescale 1ns / 1ps
// Add word: the result is set by a walk over the valid bits.
// Dispatch word: the result is set by the single key comparator reading one table slot per
// cycle, then up to five arithmetic steps.
// One word is in work at a time; the next is accepted as soon as the result sits in the
// output register. Reset (rst_ni low, asynchronous) empties the table, clears time, job
// counter and sums and sets the quantum to 2; the entry memory itself is not cleared.

module round_robin_quantum_scheduler
  import rrqs_pkg::*;
#(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Quantum write channel.
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [15:0]   cfg_data_i,
  // Input words.
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [31:0]   s_axis_tdata_i,  // arrival_time[15:0], burst_time[31:16]
  input  logic [0:0]    s_axis_tuser_i,  // op[0]
  // Result words.
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [151:0]  m_axis_tdata_o,  // job_number[7:0], slice_end_time[32:8],
                                         // turnaround[57:33], waiting[82:58],
                                         // turnaround_total[114:83],
                                         // waiting_total[146:115], zero[151:147]
  output logic [2:0]    m_axis_tuser_o   // status[1:0], finished[2]
);

  localparam int unsigned IdxW = $clog2(MAX_JOBS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_JOBS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_DSP_SCAN,
    S_DSP_DRAIN,
    S_CALC_SLICE,
    S_CALC_END,
    S_CALC_TURN,
    S_CALC_WAIT,
    S_CALC_SUM,
    S_EMIT
  } state_e;

  state_e             state_q;
  logic [ValW-1:0]    quantum_q;
  logic [MAX_JOBS-1:0] valid_q;
  logic [TimeW-1:0]   clock_now_q;
  logic [JobW-1:0]    next_job_q;
  logic [SumW-1:0]    sum_turn_q;
  logic [SumW-1:0]    sum_wait_q;

  // Word being worked on.
  logic [ValW-1:0]    arr_q;
  logic [ValW-1:0]    bur_q;
  logic [IdxW-1:0]    cnt_q;

  // Scan pipeline: the slot read last cycle and the best slot so far.
  logic               rd_pend_q;
  logic               rd_vld_q;
  logic [IdxW-1:0]    rd_slot_q;
  logic               best_vld_q;
  logic [IdxW-1:0]    best_slot_q;
  entry_t             best_q;

  // Slice arithmetic.
  logic [ValW-1:0]    run_q;
  logic [TimeW-1:0]   start_q;
  logic [TimeW-1:0]   end_q;
  logic [ValW-1:0]    rem_q;
  logic [TimeW-1:0]   turn_q;
  logic [TimeW-1:0]   wait_q;

  status_e            res_status_q;
  logic [JobW-1:0]    res_job_q;
  logic               res_finished_q;

  logic               m_valid_q;
  logic [151:0]       m_data_q;
  logic [2:0]         m_user_q;

  entry_t             rd_entry;
  logic               mem_we;
  logic [IdxW-1:0]    mem_waddr;
  entry_t             mem_wdata;
  logic               rd_less;
  logic               take_rd;
  logic               last_idx;
  logic               in_fire;
  logic               out_load;
  logic [ValW-1:0]    q_eff;
  logic [TimeW:0]     end_sum;
  logic [SumW:0]      turn_sum;
  logic [SumW:0]      wait_sum;
  logic [TimeW-1:0]   slice_end_out;
  logic [TimeW-1:0]   turn_out;
  logic [TimeW-1:0]   wait_out;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == S_EMIT) && (!m_valid_q || m_axis_tready_i);
  assign last_idx        = (cnt_q == LastIdx);

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // A quantum of zero behaves as one.
  assign q_eff = (quantum_q == '0) ? ValW'(1) : quantum_q;

  // Table writes: a new job in the first free slot, or a requeued job back in its slot.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = best_q;
    if (state_q == S_ADD_SCAN && !valid_q[cnt_q]) begin
      mem_we                   = 1'b1;
      mem_wdata.arrival        = arr_q;
      mem_wdata.burst          = bur_q;
      mem_wdata.remaining      = bur_q;
      mem_wdata.key.ready_time = TimeW'(arr_q);
      mem_wdata.key.requeued   = 1'b0;
      mem_wdata.key.job        = next_job_q;
    end else if (state_q == S_CALC_TURN && rem_q != '0) begin
      mem_we                   = 1'b1;
      mem_waddr                = best_slot_q;
      mem_wdata.remaining      = rem_q;
      mem_wdata.key.ready_time = end_q;
      mem_wdata.key.requeued   = 1'b1;
    end
  end

  rrqs_entry_mem #(
    .DEPTH (MAX_JOBS),
    .AW    (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (cnt_q),
    .rdata_o (rd_entry)
  );

  rrqs_key_cmp u_cmp (
    .a_i      (rd_entry.key),
    .b_i      (best_q.key),
    .a_less_o (rd_less)
  );

  // Slots are visited in ascending order and only a strictly smaller key
  // replaces the best, so equal keys go to the lowest slot.
  assign take_rd = rd_pend_q && rd_vld_q && (!best_vld_q || rd_less);

  assign end_sum  = {1'b0, start_q} + (TimeW + 1)'(run_q);
  assign turn_sum = {1'b0, sum_turn_q} + (SumW + 1)'(turn_q);
  assign wait_sum = {1'b0, sum_wait_q} + (SumW + 1)'(wait_q);

  // Fields that carry no meaning for a status are sent as zero.
  assign slice_end_out = (res_status_q == ST_RUN) ? end_q : '0;
  assign turn_out      = res_finished_q ? turn_q : '0;
  assign wait_out      = res_finished_q ? wait_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      quantum_q      <= ValW'(2);
      valid_q        <= '0;
      clock_now_q    <= '0;
      next_job_q     <= '0;
      sum_turn_q     <= '0;
      sum_wait_q     <= '0;
      arr_q          <= '0;
      bur_q          <= '0;
      cnt_q          <= '0;
      rd_pend_q      <= 1'b0;
      rd_vld_q       <= 1'b0;
      rd_slot_q      <= '0;
      best_vld_q     <= 1'b0;
      best_slot_q    <= '0;
      best_q         <= '0;
      run_q          <= '0;
      start_q        <= '0;
      end_q          <= '0;
      rem_q          <= '0;
      turn_q         <= '0;
      wait_q         <= '0;
      res_status_q   <= ST_ADDED;
      res_job_q      <= '0;
      res_finished_q <= 1'b0;
      m_valid_q      <= 1'b0;
      m_data_q       <= '0;
      m_user_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        quantum_q <= cfg_data_i;
      end

      // A word taken while a new result is loaded is simply replaced below.
      if (m_valid_q && m_axis_tready_i && !out_load) begin
        m_valid_q <= 1'b0;
      end

      // The scan pipeline registers each slot's flags so that they line up with the registered read data.
      rd_pend_q <= (state_q == S_DSP_SCAN);
      rd_vld_q  <= valid_q[cnt_q];
      rd_slot_q <= cnt_q;
      if (take_rd) begin
        best_vld_q  <= 1'b1;
        best_slot_q <= rd_slot_q;
        best_q      <= rd_entry;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            arr_q      <= s_axis_tdata_i[15:0];
            bur_q      <= s_axis_tdata_i[31:16];
            cnt_q      <= '0;
            best_vld_q <= 1'b0;
            state_q    <= (s_axis_tuser_i[0] == OpDispatch) ? S_DSP_SCAN : S_ADD_SCAN;
          end
        end

        S_ADD_SCAN: begin
          res_finished_q <= 1'b0;
          if (!valid_q[cnt_q]) begin
            valid_q[cnt_q] <= 1'b1;
            res_status_q   <= ST_ADDED;
            res_job_q      <= next_job_q;
            next_job_q     <= next_job_q + JobW'(1);
            state_q        <= S_EMIT;
          end else if (last_idx) begin
            res_status_q <= ST_FULL;
            res_job_q    <= '0;
            state_q      <= S_EMIT;
          end else begin
            cnt_q <= cnt_q + IdxW'(1);
          end
        end

        S_DSP_SCAN: begin
          if (last_idx) begin
            state_q <= S_DSP_DRAIN;
          end else begin
            cnt_q <= cnt_q + IdxW'(1);
          end
        end

        S_DSP_DRAIN: begin
          state_q <= S_CALC_SLICE;
        end

        S_CALC_SLICE: begin
          res_finished_q <= 1'b0;
          if (!best_vld_q) begin
            res_status_q <= ST_EMPTY;
            res_job_q    <= '0;
            state_q      <= S_EMIT;
          end else begin
            run_q   <= (best_q.remaining < q_eff) ? best_q.remaining : q_eff;
            start_q <= (clock_now_q > best_q.key.ready_time) ? clock_now_q
                                                              : best_q.key.ready_time;
            state_q <= S_CALC_END;
          end
        end

        S_CALC_END: begin
          end_q       <= end_sum[TimeW] ? TimeMax : end_sum[TimeW-1:0];
          clock_now_q <= end_sum[TimeW] ? TimeMax : end_sum[TimeW-1:0];
          rem_q       <= best_q.remaining - run_q;
          state_q     <= S_CALC_TURN;
        end

        S_CALC_TURN: begin
          res_status_q <= ST_RUN;
          res_job_q    <= best_q.key.job;
          // A slice always ends at or after the job's arrival.
          turn_q       <= end_q - TimeW'(best_q.arrival);
          if (rem_q == '0) begin
            valid_q[best_slot_q] <= 1'b0;
            res_finished_q       <= 1'b1;
            state_q              <= S_CALC_WAIT;
          end else begin
            state_q <= S_EMIT;
          end
        end

        S_CALC_WAIT: begin
          // Only a saturated clock can bring turnaround below the burst.
          wait_q  <= (turn_q >= TimeW'(best_q.burst)) ? turn_q - TimeW'(best_q.burst) : '0;
          state_q <= S_CALC_SUM;
        end

        S_CALC_SUM: begin
          sum_turn_q <= turn_sum[SumW] ? SumMax : turn_sum[SumW-1:0];
          sum_wait_q <= wait_sum[SumW] ? SumMax : wait_sum[SumW-1:0];
          state_q    <= S_EMIT;
        end

        S_EMIT: begin
          if (out_load) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {5'b0, sum_wait_q, sum_turn_q, wait_out, turn_out,
                          slice_end_out, res_job_q};
            m_user_q  <= {res_finished_q, res_status_q};
            state_q   <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Nothing to dispatch is only reported when the table really is empty.
  a_empty_means_no_jobs : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_status_q == ST_EMPTY) |-> (valid_q == '0)
  ) else $error("empty status with jobs in the table");

  // A finished job is always a dispatch result.
  a_finished_on_run : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_finished_q) |-> (res_status_q == ST_RUN)
  ) else $error("finished flag outside a slice result");

  // Scheduler time never moves backward.
  a_clock_monotonic : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (clock_now_q >= $past(clock_now_q))
  ) else $error("clock went backward");

  // A word is only taken while no result is under construction.
  a_accept_idle : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_ADD_SCAN || state_q == S_DSP_SCAN)
  ) else $error("accepted word did not start a scan");

endmodule
